/* design/lidar_polar_to_cartesian_defines.svh */
// Assertion macros shared by the lidar polar-to-Cartesian checker
`ifndef LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LPC_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LPC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

/* design/lpc_pkg.sv */
// Types, widths, register codes and the arctangent table of the polar-to-Cartesian block
package lpc_pkg;

   // Port widths
   localparam int RANGE_W     = 16;
   localparam int BEAM_W      = 12;
   localparam int COORD_W     = 17;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_OF_VIEW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP    = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] RANGE_LIMIT_RESET   = 16'hFFFF;
   localparam logic [CFG_W-1:0] FIELD_OF_VIEW_RESET = 16'h8000;
   localparam logic [CFG_W-1:0] ANGLE_STEP_RESET    = 16'h0080;

   // Beams at or beyond this count are dropped
   localparam int unsigned MAX_BEAMS = 4096;

   // Datapath: range scaled by the CORDIC gain leaves 14 extra fraction bits
   localparam int ANGLE_W   = 16;
   localparam int GAIN_W    = 30;
   localparam int SCALED_W  = RANGE_W + GAIN_W - 16;
   localparam int XW        = 34;
   localparam int ZW        = 33;
   localparam int FRAC_EXTRA = 14;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
   localparam logic signed [XW-1:0] ROUND_BIAS = 34'sd8192;
   localparam int COORD_MAX = 65535;

   // atan(2^-i), full turn = 2^32
   localparam int ATAN_ENTRIES = 24;
   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Vector handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic signed [XW-1:0]    x;
      logic signed [XW-1:0]    y;
      logic signed [ZW-1:0]    z;
      logic [BEAM_W-1:0]       beam;
   } cell_data_type;

endpackage

/* design/lidar_polar_to_cartesian.sv */
// Top level: lidar beam polar-to-Cartesian converter with a chain of CORDIC cells
//
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   range_reading[15:0], beam_index[11:0]
//  rsp_      out        rsp_valid / rsp_ready   point_x[16:0], point_y[16:0], point_beam[11:0]
//  csr_      in         csr_valid / csr_ready   csr_index[1:0], csr_data[15:0]
//
//  One transaction per cycle while the skid register is empty; between the accepting
//  edge and rsp_valid lie three front stages (the first loaded at that edge),
//  one cell per rotation stage and the output register.
//  Reset is synchronous and clears valid bits and the registers to defaults.
//  A stalled output parks one result in the skid register; req_ready drops
//  only while that register is full and the whole chain then holds.
module lidar_polar_to_cartesian #(
   parameter int ROTATION_STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lpc_pkg::RANGE_W-1:0]          req_range_reading,
   input  logic [lpc_pkg::BEAM_W-1:0]           req_beam_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lpc_pkg::COORD_W-1:0]   rsp_point_x,
   output logic signed [lpc_pkg::COORD_W-1:0]   rsp_point_y,
   output logic [lpc_pkg::BEAM_W-1:0]           rsp_point_beam,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lpc_pkg::CFG_W-1:0]            csr_data
);
   import lpc_pkg::*;

   logic [CFG_W-1:0] range_limit_ff, range_limit_in;
   logic [CFG_W-1:0] fov_ff, fov_in;
   logic [CFG_W-1:0] step_ff, step_in;
   logic             enable;
   cell_data_type    chain [ROTATION_STAGES+1];

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      range_limit_in = range_limit_ff;
      fov_in         = fov_ff;
      step_in        = step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_LIMIT:   range_limit_in = csr_data;
            CSR_FIELD_OF_VIEW: fov_in         = csr_data;
            CSR_ANGLE_STEP:    step_in        = csr_data;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_limit_ff <= RANGE_LIMIT_RESET;
         fov_ff         <= FIELD_OF_VIEW_RESET;
         step_ff        <= ANGLE_STEP_RESET;
      end else begin
         range_limit_ff <= range_limit_in;
         fov_ff         <= fov_in;
         step_ff        <= step_in;
      end
   end

   assign req_ready = enable;

   // Angle, gain and fold
   lpc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .enable            (enable),
      .req_valid         (req_valid),
      .req_range_reading (req_range_reading),
      .req_beam_index    (req_beam_index),
      .range_limit       (range_limit_ff),
      .field_of_view     (fov_ff),
      .angle_step        (step_ff),
      .front_out         (chain[0])
   );

   // Rotation cells
   for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
      lpc_cordic_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // Rounding and output buffering
   lpc_output u_output (
      .clock          (clock),
      .reset          (reset),
      .out_in         (chain[ROTATION_STAGES]),
      .enable         (enable),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_beam (rsp_point_beam)
   );

endmodule

/* design/lpc_front.sv */
// Front end: range check, beam angle, gain scaling and quadrant fold
module lpc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          req_valid,
   input  logic [lpc_pkg::RANGE_W-1:0]   req_range_reading,
   input  logic [lpc_pkg::BEAM_W-1:0]    req_beam_index,
   input  logic [lpc_pkg::CFG_W-1:0]     range_limit,
   input  logic [lpc_pkg::CFG_W-1:0]     field_of_view,
   input  logic [lpc_pkg::CFG_W-1:0]     angle_step,
   output lpc_pkg::cell_data_type        front_out
);
   import lpc_pkg::*;

   localparam int PROD_W = BEAM_W + CFG_W;
   localparam int MULT_W = RANGE_W + GAIN_W;

   logic                  valid_a_ff, valid_a_in;
   logic [RANGE_W-1:0]    range_a_ff;
   logic [BEAM_W-1:0]     beam_a_ff;
   logic [ANGLE_W-1:0]    prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]     prod_full;

   logic                  valid_b_ff;
   logic [SCALED_W-1:0]   scaled_b_ff, scaled_b_in;
   logic [ANGLE_W-1:0]    angle_b_ff, angle_b_in;
   logic [BEAM_W-1:0]     beam_b_ff;
   logic [MULT_W-1:0]     mult_full;

   logic                  valid_c_ff;
   logic signed [XW-1:0]  x_c_ff, x_c_in;
   logic signed [ZW-1:0]  z_c_ff, z_c_in;
   logic [BEAM_W-1:0]     beam_c_ff;
   logic                  fold;
   logic [ANGLE_W-1:0]    angle_fold;

   // Stage A: drop check and index times step
   assign valid_a_in = req_valid && (req_range_reading < range_limit)
                       && (32'(req_beam_index) < MAX_BEAMS);
   assign prod_full  = PROD_W'(req_beam_index) * PROD_W'(angle_step);
   assign prod_a_in  = prod_full[ANGLE_W-1:0];

   // Stage B: beam angle and range times gain
   assign angle_b_in  = prod_a_ff - {1'b0, field_of_view[CFG_W-1:1]};
   assign mult_full   = MULT_W'(range_a_ff) * MULT_W'(GAIN_Q30);
   assign scaled_b_in = mult_full[MULT_W-1:16];

   // Stage C: fold angles of the left half plane onto the right half
   assign fold       = (angle_b_ff[ANGLE_W-1:ANGLE_W-2] == 2'b01)
                       || (angle_b_ff[ANGLE_W-1:ANGLE_W-2] == 2'b10);
   assign angle_fold = fold ? (angle_b_ff - 16'h8000) : angle_b_ff;
   assign x_c_in     = fold ? -signed'(XW'(scaled_b_ff)) : signed'(XW'(scaled_b_ff));
   assign z_c_in     = signed'({{(ZW-32){angle_fold[ANGLE_W-1]}}, angle_fold, 16'h0000});

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (enable) begin
         range_a_ff  <= req_range_reading;
         beam_a_ff   <= req_beam_index;
         prod_a_ff   <= prod_a_in;
         scaled_b_ff <= scaled_b_in;
         angle_b_ff  <= angle_b_in;
         beam_b_ff   <= beam_a_ff;
         x_c_ff      <= x_c_in;
         z_c_ff      <= z_c_in;
         beam_c_ff   <= beam_b_ff;
      end
   end

   assign front_out.valid = valid_c_ff;
   assign front_out.x     = x_c_ff;
   assign front_out.y     = '0;
   assign front_out.z     = z_c_ff;
   assign front_out.beam  = beam_c_ff;

endmodule

/* design/lpc_cordic_cell.sv */
// One CORDIC rotation cell: a shift-add micro-rotation and its angle update
module lpc_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  lpc_pkg::cell_data_type  cell_in,
   output lpc_pkg::cell_data_type  cell_out
);
   import lpc_pkg::*;

   logic                  valid_ff;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [BEAM_W-1:0]     beam_ff;
   logic signed [XW-1:0]  dx, dy;
   logic signed [ZW-1:0]  atan_s;

   assign dx     = cell_in.y >>> SHIFT;
   assign dy     = cell_in.x >>> SHIFT;
   assign atan_s = signed'(ZW'(ATAN_TABLE[SHIFT]));

   // Rotate toward zero residual angle
   always_comb begin
      if (!cell_in.z[ZW-1]) begin
         x_in = cell_in.x - dx;
         y_in = cell_in.y + dy;
         z_in = cell_in.z - atan_s;
      end else begin
         x_in = cell_in.x + dx;
         y_in = cell_in.y - dy;
         z_in = cell_in.z + atan_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         beam_ff <= cell_in.beam;
      end
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.x     = x_ff;
   assign cell_out.y     = y_ff;
   assign cell_out.z     = z_ff;
   assign cell_out.beam  = beam_ff;

endmodule

/* design/lpc_output.sv */
// Output stage: rounding, saturation, output register and skid register
module lpc_output (
   input  logic                                clock,
   input  logic                                reset,
   input  lpc_pkg::cell_data_type              out_in,
   output logic                                enable,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lpc_pkg::COORD_W-1:0]  rsp_point_x,
   output logic signed [lpc_pkg::COORD_W-1:0]  rsp_point_y,
   output logic [lpc_pkg::BEAM_W-1:0]          rsp_point_beam
);
   import lpc_pkg::*;

   localparam int SH_W = XW - FRAC_EXTRA;

   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [BEAM_W-1:0]         out_beam_ff, out_beam_in;
   logic signed [COORD_W-1:0] skid_x_ff, skid_x_in, skid_y_ff, skid_y_in;
   logic [BEAM_W-1:0]         skid_beam_ff, skid_beam_in;
   logic signed [COORD_W-1:0] new_x, new_y;
   logic                      arriving, take;

   // Round half up, drop the extra fraction bits, clamp to +/-65535
   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [XW-1:0] v);
      logic signed [XW-1:0]   biased;
      logic signed [SH_W-1:0] sh;
      biased = v + ROUND_BIAS;
      sh     = SH_W'(biased >>> FRAC_EXTRA);
      if (sh > signed'(SH_W'(COORD_MAX))) begin
         round_sat = signed'(COORD_W'(COORD_MAX));
      end else if (sh < -signed'(SH_W'(COORD_MAX))) begin
         round_sat = -signed'(COORD_W'(COORD_MAX));
      end else begin
         round_sat = sh[COORD_W-1:0];
      end
   endfunction

   assign new_x    = round_sat(out_in.x);
   assign new_y    = round_sat(out_in.y);
   assign enable   = !skid_valid_ff;
   assign arriving = out_in.valid && enable;
   assign take     = !out_valid_ff || rsp_ready;

   // Output register refills from skid first, else from the pipeline
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_beam_in   = out_beam_ff;
      skid_valid_in = skid_valid_ff;
      skid_x_in     = skid_x_ff;
      skid_y_in     = skid_y_ff;
      skid_beam_in  = skid_beam_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_x_in      = skid_x_ff;
            out_y_in      = skid_y_ff;
            out_beam_in   = skid_beam_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = arriving;
            out_x_in     = new_x;
            out_y_in     = new_y;
            out_beam_in  = out_in.beam;
         end
      end else if (arriving) begin
         skid_valid_in = 1'b1;
         skid_x_in     = new_x;
         skid_y_in     = new_y;
         skid_beam_in  = out_in.beam;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_beam_ff  <= out_beam_in;
      skid_x_ff    <= skid_x_in;
      skid_y_ff    <= skid_y_in;
      skid_beam_ff <= skid_beam_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_point_beam = out_beam_ff;

endmodule

/* design/lpc_checker.sv */
// Port-level checker for the lidar polar-to-Cartesian block, bound to the top level
`include "lidar_polar_to_cartesian_defines.svh"

module lpc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [lpc_pkg::RANGE_W-1:0]          req_range_reading,
   input logic [lpc_pkg::BEAM_W-1:0]           req_beam_index,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [lpc_pkg::COORD_W-1:0]   rsp_point_x,
   input logic signed [lpc_pkg::COORD_W-1:0]   rsp_point_y,
   input logic [lpc_pkg::BEAM_W-1:0]           rsp_point_beam,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [lpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input logic [lpc_pkg::CFG_W-1:0]            csr_data
);
   import lpc_pkg::*;

   logic rsp_stall;
   logic coord_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign coord_ok  = (rsp_point_x != 17'h10000) && (rsp_point_y != 17'h10000);

   // A held result stays
   `LPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "rsp_valid dropped while stalled")
   // A held result keeps its payload
   `LPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_beam), "rsp payload changed while stalled")
   // Input backpressure only comes from a waiting result
   `LPC_ASSERT_NOW(a_ready_cause, clock, reset, !req_ready, rsp_valid, "req_ready low with no result pending")
   // Saturation never yields the most negative code
   `LPC_ASSERT_NOW(a_coord_range, clock, reset, rsp_valid, coord_ok, "coordinate outside +/-65535")

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (.*);

/* bench/lidar_polar_to_cartesian_tb.sv */
// Self-checking testbench for the lidar polar-to-Cartesian converter
module lidar_polar_to_cartesian_tb;
   import lpc_pkg::*;

   localparam int ROTATION_STAGES = 16;
   localparam int LATENCY         = ROTATION_STAGES + 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int N_DIRECTED      = 15;
   localparam int N_SCAN_PHASES   = 4;
   localparam int N_RANDOM_CFG    = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [BEAM_W-1:0]         beam;
   } point_type;

   // How the expected point of a directed row is obtained
   typedef enum logic [1:0] {ROW_PREDICTED, ROW_ORIGIN, ROW_DROPPED} row_kind_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_reading;
      logic [BEAM_W-1:0]  beam_index;
      row_kind_type       kind;
   } row_type;

   typedef struct packed {
      logic [CFG_W-1:0] range_limit;
      logic [CFG_W-1:0] fov;
      logic [CFG_W-1:0] step;
      logic [15:0]      items;
      bit               src_idle;
      bit               sink_idle;
      bit               hold;
   } scan_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [RANGE_W-1:0]         req_range_reading = '0;
   logic [BEAM_W-1:0]          req_beam_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [COORD_W-1:0]  rsp_point_x;
   logic signed [COORD_W-1:0]  rsp_point_y;
   logic [BEAM_W-1:0]          rsp_point_beam;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CFG_W-1:0]           csr_data = '0;

   // Register copies used for prediction
   logic [CFG_W-1:0] cfg_range_limit = RANGE_LIMIT_RESET;
   logic [CFG_W-1:0] cfg_fov         = FIELD_OF_VIEW_RESET;
   logic [CFG_W-1:0] cfg_step        = ANGLE_STEP_RESET;

   point_type        pending_points[$];
   int               error_count = 0;
   int               quiet_cycles = 0;
   bit               src_idling = 1'b1;
   bit               sink_idling = 1'b1;
   bit               hold_request = 1'b0;
   logic [BEAM_W-1:0] sweep_beam = '0;

   // Directed rows, run under the reset register values
   row_type directed_rows [N_DIRECTED] = '{
      '{16'd0,     12'd0,    ROW_ORIGIN},
      '{16'd0,     12'd4095, ROW_ORIGIN},
      '{16'hFFFF,  12'd128,  ROW_DROPPED},
      '{16'hFFFE,  12'd128,  ROW_PREDICTED},
      '{16'hFFFE,  12'd0,    ROW_PREDICTED},
      '{16'hFFFE,  12'd256,  ROW_PREDICTED},
      '{16'hFFFE,  12'd384,  ROW_PREDICTED},
      '{16'hFFFE,  12'd4095, ROW_PREDICTED},
      '{16'd1,     12'd128,  ROW_PREDICTED},
      '{16'h8000,  12'd64,   ROW_PREDICTED},
      '{16'h5555,  12'd200,  ROW_PREDICTED},
      '{16'hAAAA,  12'd4000, ROW_PREDICTED},
      '{16'hFFFF,  12'd4095, ROW_DROPPED},
      '{16'd1024,  12'd320,  ROW_PREDICTED},
      '{16'd1024,  12'd192,  ROW_PREDICTED}
   };

   // Fixed register settings: pressure, zero range, odd fov, tiny range
   scan_cfg_type scan_phases [N_SCAN_PHASES] = '{
      '{16'hFFFF, 16'hFFFF, 16'h0010, 16'd200, 1'b0, 1'b0, 1'b1},
      '{16'h0000, 16'h0000, 16'h0000, 16'd40,  1'b1, 1'b1, 1'b0},
      '{16'h8000, 16'h0001, 16'hFFFF, 16'd200, 1'b1, 1'b1, 1'b0},
      '{16'h0001, 16'h8000, 16'h0001, 16'd40,  1'b1, 1'b0, 1'b0}
   };

   lidar_polar_to_cartesian #(
      .ROTATION_STAGES (ROTATION_STAGES)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_range_reading (req_range_reading),
      .req_beam_index    (req_beam_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_beam    (rsp_point_beam),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < -COORD_MAX) v = -COORD_MAX;
      return COORD_W'(v);
   endfunction

   // Range check, beam angle, gain scaling, quadrant fold, CORDIC rotation and rounding
   function automatic bit convert_beam(input logic [RANGE_W-1:0] rng,
                                       input logic [BEAM_W-1:0] beam,
                                       output point_type pt);
      logic [ANGLE_W-1:0] angle;
      logic [31:0]        z32;
      longint             x, y, z, dx, dy;
      int                 i;
      pt = '0;
      if (rng >= cfg_range_limit) return 1'b0;
      angle = ANGLE_W'(32'(beam) * 32'(cfg_step) - 32'(cfg_fov >> 1));
      z32 = {angle, 16'h0000};
      x = longint'((64'(rng) * 64'(GAIN_Q30)) >> 16);
      y = 0;
      if (z32[31:30] == 2'b01 || z32[31:30] == 2'b10) begin
         x = -x;
         z32 = z32 - 32'h8000_0000;
      end
      z = longint'($signed(z32));
      for (i = 0; i < ROTATION_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TABLE[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TABLE[i]);
         end
      end
      pt.x = clamp_coord((x + 8192) >>> FRAC_EXTRA);
      pt.y = clamp_coord((y + 8192) >>> FRAC_EXTRA);
      pt.beam = beam;
      return 1'b1;
   endfunction

   // Offer one reading and hold it until the transaction completes
   task automatic send_reading(input logic [RANGE_W-1:0] rng, input logic [BEAM_W-1:0] beam,
                               input bit has_pt, input point_type pt);
      req_valid <= 1'b1;
      req_range_reading <= rng;
      req_beam_index <= beam;
      do @(posedge clock); while (!req_ready);
      if (has_pt) pending_points = {pending_points, pt};
   endtask

   task automatic source_gap();
      if (src_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Mostly beam sweeps within range; some readings on the limit and anywhere
   task automatic offer_random_reading();
      logic [RANGE_W-1:0] rng;
      logic [BEAM_W-1:0]  beam;
      point_type          pt;
      bit                 has_pt;
      int                 pick;
      pick = $urandom_range(0, 9);
      if (pick < 6 && cfg_range_limit != 0)
         rng = RANGE_W'($urandom_range(0, cfg_range_limit - 1));
      else if (pick == 6)
         rng = cfg_range_limit;
      else if (pick == 7)
         rng = cfg_range_limit - 1'b1;
      else
         rng = RANGE_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 7) begin
         beam = sweep_beam;
         sweep_beam = sweep_beam + 1'b1;
      end else begin
         beam = BEAM_W'($urandom_range(0, 4095));
      end
      has_pt = convert_beam(rng, beam, pt);
      send_reading(rng, beam, has_pt, pt);
      source_gap();
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RANGE_LIMIT:   cfg_range_limit = val;
         CSR_FIELD_OF_VIEW: cfg_fov = val;
         CSR_ANGLE_STEP:    cfg_step = val;
         default: ;
      endcase
   endtask

   // Drain: all points back, then let dropped readings leave the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic run_scan(input scan_cfg_type sc);
      settle();
      write_register(CSR_RANGE_LIMIT, sc.range_limit);
      write_register(CSR_FIELD_OF_VIEW, sc.fov);
      write_register(CSR_ANGLE_STEP, sc.step);
      csr_valid <= 1'b0;
      src_idling = sc.src_idle;
      sink_idling = sc.sink_idle;
      if (sc.hold) hold_request = 1'b1;
      sweep_beam = BEAM_W'($urandom_range(0, 4095));
      repeat (sc.items) offer_random_reading();
   endtask

   // Stimulus
   initial begin
      point_type    pt;
      bit           has_pt;
      scan_cfg_type sc;
      int           n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under reset values
      for (n = 0; n < N_DIRECTED; n++) begin
         case (directed_rows[n].kind)
            ROW_ORIGIN: begin
               has_pt = 1'b1;
               pt = '{x: '0, y: '0, beam: directed_rows[n].beam_index};
            end
            ROW_DROPPED: begin
               has_pt = 1'b0;
               pt = '0;
            end
            default: has_pt = convert_beam(directed_rows[n].range_reading,
                                           directed_rows[n].beam_index, pt);
         endcase
         send_reading(directed_rows[n].range_reading, directed_rows[n].beam_index, has_pt, pt);
         source_gap();
      end

      // Write to the index past the register list must change nothing
      settle();
      write_register(CSR_UNUSED, 16'h0000);
      csr_valid <= 1'b0;
      repeat (100) offer_random_reading();

      for (n = 0; n < N_SCAN_PHASES; n++) run_scan(scan_phases[n]);

      // Random register settings; the last one runs without idling
      for (n = 0; n < N_RANDOM_CFG; n++) begin
         sc.range_limit = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                      : CFG_W'($urandom_range(16'h4000, 16'hFFFF));
         sc.fov = CFG_W'($urandom_range(0, 65535));
         sc.step = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 65535))
                                        : CFG_W'($urandom_range(0, 64));
         sc.items = (n == N_RANDOM_CFG - 1) ? 16'd150 : 16'd200;
         sc.src_idle = (n != N_RANDOM_CFG - 1);
         sc.sink_idle = (n != N_RANDOM_CFG - 1);
         sc.hold = 1'b0;
         run_scan(sc);
      end

      settle();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (sink_idling && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result transaction with the oldest expected point
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point: x %0d y %0d beam %0d",
                   rsp_point_x, rsp_point_y, rsp_point_beam);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_x !== want.x) begin
               $error("point_x expected %0d got %0d", want.x, rsp_point_x);
               error_count++;
            end
            if (rsp_point_y !== want.y) begin
               $error("point_y expected %0d got %0d", want.y, rsp_point_y);
               error_count++;
            end
            if (rsp_point_beam !== want.beam) begin
               $error("point_beam expected %0d got %0d", want.beam, rsp_point_beam);
               error_count++;
            end
         end
      end
   end

   // Watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* lidar_polar_to_cartesian.f */
+incdir+design
design/lpc_pkg.sv
design/lpc_front.sv
design/lpc_cordic_cell.sv
design/lpc_output.sv
design/lidar_polar_to_cartesian.sv
design/lpc_checker.sv
bench/lidar_polar_to_cartesian_tb.sv
